@@ hw/rtl/srarq_pkg.sv @@
// shared types, codes and helpers of the selective-repeat arq engine
package srarq_pkg;

   localparam int SEQ_BITS  = 3;
   localparam int SLOT_BITS = SEQ_BITS - 1;
   localparam int NR_BUFS   = 1 << SLOT_BITS;
   localparam int PAY_W     = 32;
   localparam int CNT_BITS  = SLOT_BITS + 1;

   localparam logic [2:0] FUNC_FRAME   = 3'd0;
   localparam logic [2:0] FUNC_CKSUM   = 3'd1;
   localparam logic [2:0] FUNC_TIMEOUT = 3'd2;
   localparam logic [2:0] FUNC_NEW     = 3'd3;
   localparam logic [2:0] FUNC_ACK_TO  = 3'd4;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   localparam logic [1:0] ACT_SEND    = 2'd0;
   localparam logic [1:0] ACT_DELIVER = 2'd1;
   localparam logic [1:0] ACT_STATUS  = 2'd2;

   localparam logic [1:0] ACKT_NONE  = 2'd0;
   localparam logic [1:0] ACKT_START = 2'd1;
   localparam logic [1:0] ACKT_STOP  = 2'd2;

   typedef struct packed {
      logic [2:0]          func;
      logic [1:0]          rx_kind;
      logic [SEQ_BITS-1:0] rx_seq;
      logic [SEQ_BITS-1:0] rx_ack;
      logic [PAY_W-1:0]    payload_in;
      logic [SEQ_BITS-1:0] timeout_seq;
   } req_type;

   typedef struct packed {
      logic [1:0]           action;
      logic [1:0]           tx_kind;
      logic [SEQ_BITS-1:0]  tx_seq;
      logic [SEQ_BITS-1:0]  tx_ack;
      logic [PAY_W-1:0]     payload_out;
      logic                 arm_timer;
      logic [SLOT_BITS-1:0] timer_slot;
      logic [NR_BUFS-1:0]   stop_timer_mask;
      logic [1:0]           ack_timer_cmd;
      logic                 net_enable;
      logic                 last;
   } rsp_type;

   // circular a <= b < c
   function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                      input logic [SEQ_BITS-1:0] b,
                                      input logic [SEQ_BITS-1:0] c);
      in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction

endpackage

@@ hw/rtl/selective_repeat_arq_engine.sv @@
// selective-repeat arq endpoint: sequencer around the send and receive stores
//
//   channel  ports                       handshake
//   req      start, busy, req_data       taken when start and not busy
//   rsp      rsp_valid, rsp_data         no back pressure
//
// while busy: a plan state that reads and updates the stores, then the results in
// order (optional frame, up to four deliveries, optional resend, closing status).
// results follow one another with no gaps; the next item is taken only from the
// idle state that follows the status item.
// synchronous reset clears the window state and the arrival bits; the stores
// hold no reset value. busy is high from acceptance until the status item.
module selective_repeat_arq_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  srarq_pkg::req_type  req_data,
   output logic                rsp_valid,
   output srarq_pkg::rsp_type  rsp_data
);

   localparam int SB = srarq_pkg::SEQ_BITS;
   localparam int LB = srarq_pkg::SLOT_BITS;
   localparam int NB = srarq_pkg::NR_BUFS;
   localparam int PW = srarq_pkg::PAY_W;
   localparam int CB = srarq_pkg::CNT_BITS;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PLAN   = 6'b000010,
      S_FRAME  = 6'b000100,
      S_DELIV  = 6'b001000,
      S_RESEND = 6'b010000,
      S_STATUS = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [SB-1:0] sle_ff, sle_in, sn_ff, sn_in, rle_ff, rle_in, rhe_ff, rhe_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          nak_ok_ff, nak_ok_in;
   logic [NB-1:0] map_ff, map_in;

   srarq_pkg::req_type req_ff;

   logic          frame_ff, frame_in;
   logic [1:0]    fkind_ff, fkind_in;
   logic [SB-1:0] fseq_ff, fseq_in;
   logic [SB-1:0] ack_ff;
   logic          resend_ff, resend_in;
   logic [SB-1:0] rseq_ff;
   logic [CB-1:0] left_ff, left_in;
   logic [LB-1:0] dslot_ff, dslot_in;
   logic [NB-1:0] stopm_ff;
   logic [1:0]    ackcmd_ff;
   logic          net_ff;
   logic          arr_ff;

   logic [PW-1:0] send_mem [NB];
   logic [PW-1:0] recv_mem [NB];
   logic [PW-1:0] send_rd_ff, recv_rd_ff;

   // plan logic
   logic          is_rx, is_data, is_nak, new_ok, nak_first, arr_ok, want_ok, ack_in_win;
   logic [SB-1:0] want, nacks;
   logic [LB-1:0] arr_slot, s_rd_addr, r_rd_addr;
   logic [NB-1:0] m_set, stopm;
   logic [CB-1:0] dcnt, cnt_dec;
   logic          run;
   logic [1:0]    ackcmd;

   always_comb begin
      is_rx     = req_ff.func == srarq_pkg::FUNC_FRAME;
      is_data   = is_rx && (req_ff.rx_kind == srarq_pkg::KIND_DATA);
      is_nak    = is_rx && (req_ff.rx_kind == srarq_pkg::KIND_NAK);
      new_ok    = cnt_ff < CB'(NB);
      nak_first = (req_ff.rx_seq != rle_ff) && nak_ok_ff;
      arr_slot  = req_ff.rx_seq[LB-1:0];
      arr_ok    = is_data && srarq_pkg::in_window(rle_ff, req_ff.rx_seq, rhe_ff)
                  && !map_ff[arr_slot];
      want      = req_ff.rx_ack + SB'(1);
      want_ok   = is_nak && srarq_pkg::in_window(sle_ff, want, sn_ff);
      m_set     = map_ff | (arr_ok ? (NB'(1) << arr_slot) : '0);
      dcnt      = '0;
      run       = 1'b1;
      for (int k = 0; k < NB; k++) begin
         if (run && m_set[LB'(rle_ff[LB-1:0] + LB'(k))]) begin
            dcnt = dcnt + CB'(1);
         end else begin
            run = 1'b0;
         end
      end
      ack_in_win = is_rx && srarq_pkg::in_window(sle_ff, req_ff.rx_ack, sn_ff);
      nacks      = ack_in_win ? SB'(req_ff.rx_ack - sle_ff + SB'(1)) : '0;
      stopm      = '0;
      for (int k = 0; k < NB; k++) begin
         if (SB'(k) < nacks) begin
            stopm[LB'(sle_ff[LB-1:0] + LB'(k))] = 1'b1;
         end
      end
      cnt_dec   = (CB'(nacks) < cnt_ff) ? CB'(nacks) : cnt_ff;
      ackcmd    = (is_data && !nak_first && dcnt == '0) ? srarq_pkg::ACKT_START
                                                         : srarq_pkg::ACKT_NONE;
      s_rd_addr = (req_ff.func == srarq_pkg::FUNC_TIMEOUT) ? req_ff.timeout_seq[LB-1:0]
                                                            : want[LB-1:0];
      r_rd_addr = (state_ff == S_PLAN) ? rle_ff[LB-1:0] : LB'(dslot_ff + LB'(1));
   end

   always_comb begin
      state_in  = state_ff;
      sle_in    = sle_ff;
      sn_in     = sn_ff;
      rle_in    = rle_ff;
      rhe_in    = rhe_ff;
      cnt_in    = cnt_ff;
      nak_ok_in = nak_ok_ff;
      map_in    = map_ff;
      frame_in  = frame_ff;
      fkind_in  = fkind_ff;
      fseq_in   = fseq_ff;
      resend_in = resend_ff;
      left_in   = left_ff;
      dslot_in  = dslot_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_PLAN;
         end
         S_PLAN: begin
            frame_in  = 1'b0;
            fkind_in  = srarq_pkg::KIND_DATA;
            fseq_in   = '0;
            resend_in = want_ok;
            left_in   = '0;
            dslot_in  = rle_ff[LB-1:0];
            case (req_ff.func)
               srarq_pkg::FUNC_NEW: begin
                  if (new_ok) begin
                     frame_in = 1'b1;
                     fseq_in  = sn_ff;
                     sn_in    = sn_ff + SB'(1);
                     cnt_in   = cnt_ff + CB'(1);
                  end
               end
               srarq_pkg::FUNC_FRAME: begin
                  if (is_data) begin
                     if (nak_first) begin
                        frame_in  = 1'b1;
                        fkind_in  = srarq_pkg::KIND_NAK;
                        nak_ok_in = 1'b0;
                     end
                     if (arr_ok) begin
                        left_in = dcnt;
                        map_in  = m_set;
                        for (int k = 0; k < NB; k++) begin
                           if (CB'(k) < dcnt) map_in[LB'(rle_ff[LB-1:0] + LB'(k))] = 1'b0;
                        end
                        rle_in = rle_ff + SB'(dcnt);
                        rhe_in = rhe_ff + SB'(dcnt);
                        if (dcnt != '0) nak_ok_in = 1'b1;
                     end
                  end
                  sle_in = sle_ff + nacks;
                  cnt_in = cnt_ff - cnt_dec;
               end
               srarq_pkg::FUNC_CKSUM: begin
                  if (nak_ok_ff) begin
                     frame_in  = 1'b1;
                     fkind_in  = srarq_pkg::KIND_NAK;
                     nak_ok_in = 1'b0;
                  end
               end
               srarq_pkg::FUNC_TIMEOUT: begin
                  frame_in = 1'b1;
                  fseq_in  = req_ff.timeout_seq;
               end
               srarq_pkg::FUNC_ACK_TO: begin
                  frame_in = 1'b1;
                  fkind_in = srarq_pkg::KIND_ACK;
               end
               default: ;
            endcase
            if (frame_in)               state_in = S_FRAME;
            else if (left_in != '0)     state_in = S_DELIV;
            else if (resend_in)         state_in = S_RESEND;
            else                        state_in = S_STATUS;
         end
         S_FRAME: begin
            if (left_ff != '0)  state_in = S_DELIV;
            else if (resend_ff) state_in = S_RESEND;
            else                state_in = S_STATUS;
         end
         S_DELIV: begin
            left_in  = left_ff - CB'(1);
            dslot_in = dslot_ff + LB'(1);
            if (left_ff == CB'(1)) state_in = resend_ff ? S_RESEND : S_STATUS;
         end
         S_RESEND: state_in = S_STATUS;
         S_STATUS: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sle_ff    <= '0;
         sn_ff     <= '0;
         rle_ff    <= '0;
         rhe_ff    <= SB'(NB);
         cnt_ff    <= '0;
         nak_ok_ff <= 1'b1;
         map_ff    <= '0;
         frame_ff  <= 1'b0;
         resend_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         sle_ff    <= sle_in;
         sn_ff     <= sn_in;
         rle_ff    <= rle_in;
         rhe_ff    <= rhe_in;
         cnt_ff    <= cnt_in;
         nak_ok_ff <= nak_ok_in;
         map_ff    <= map_in;
         frame_ff  <= frame_in;
         resend_ff <= resend_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      fkind_ff <= fkind_in;
      fseq_ff  <= fseq_in;
      dslot_ff <= dslot_in;
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      if (state_ff == S_PLAN) begin
         ack_ff    <= rle_ff - SB'(1);
         rseq_ff   <= want;
         stopm_ff  <= stopm;
         ackcmd_ff <= ackcmd;
         net_ff    <= cnt_in < CB'(NB);
         arr_ff    <= arr_ok;
      end
   end

   // stores: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_PLAN && req_ff.func == srarq_pkg::FUNC_NEW && new_ok)
         send_mem[sn_ff[LB-1:0]] <= req_ff.payload_in;
      if (state_ff == S_PLAN) send_rd_ff <= send_mem[s_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PLAN && arr_ok) recv_mem[arr_slot] <= req_ff.payload_in;
      if (state_ff == S_PLAN || state_ff == S_DELIV) recv_rd_ff <= recv_mem[r_rd_addr];
   end

   assign busy = state_ff != S_IDLE;

   always_comb begin
      rsp_valid  = 1'b0;
      rsp_data   = '0;
      rsp_data.net_enable = net_ff;
      case (state_ff)
         S_FRAME: begin
            rsp_valid              = 1'b1;
            rsp_data.action        = srarq_pkg::ACT_SEND;
            rsp_data.tx_kind       = fkind_ff;
            rsp_data.tx_seq        = fseq_ff;
            rsp_data.tx_ack        = ack_ff;
            rsp_data.ack_timer_cmd = srarq_pkg::ACKT_STOP;
            if (fkind_ff == srarq_pkg::KIND_DATA) begin
               rsp_data.payload_out = (req_ff.func == srarq_pkg::FUNC_NEW) ?
                                      req_ff.payload_in : send_rd_ff;
               rsp_data.arm_timer   = 1'b1;
               rsp_data.timer_slot  = fseq_ff[LB-1:0];
            end
         end
         S_DELIV: begin
            rsp_valid              = 1'b1;
            rsp_data.action        = srarq_pkg::ACT_DELIVER;
            rsp_data.payload_out   = (arr_ff && dslot_ff == req_ff.rx_seq[LB-1:0]) ?
                                     req_ff.payload_in : recv_rd_ff;
            rsp_data.ack_timer_cmd = srarq_pkg::ACKT_START;
         end
         S_RESEND: begin
            rsp_valid              = 1'b1;
            rsp_data.action        = srarq_pkg::ACT_SEND;
            rsp_data.tx_kind       = srarq_pkg::KIND_DATA;
            rsp_data.tx_seq        = rseq_ff;
            rsp_data.tx_ack        = ack_ff;
            rsp_data.payload_out   = send_rd_ff;
            rsp_data.arm_timer     = 1'b1;
            rsp_data.timer_slot    = rseq_ff[LB-1:0];
            rsp_data.ack_timer_cmd = srarq_pkg::ACKT_STOP;
         end
         S_STATUS: begin
            rsp_valid                = 1'b1;
            rsp_data.action          = srarq_pkg::ACT_STATUS;
            rsp_data.stop_timer_mask = stopm_ff;
            rsp_data.ack_timer_cmd   = ackcmd_ff;
            rsp_data.last            = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/srarq_checker.sv @@
// port-level checks of the arq engine and their binding
module srarq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input srarq_pkg::rsp_type rsp_data
);

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("item shown while idle");

   a_plan_gap: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid)) else $error("no plan cycle");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !busy) else $error("busy after last item");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> rsp_valid) else $error("gap between items");

   a_fell: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid && rsp_data.last)) else $error("busy fell early");

endmodule

bind selective_repeat_arq_engine srarq_checker u_srarq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
